>>> rtl/core/sse_pkg.sv
// ----------------------------------------------------------------------------
// sse_pkg
// Shared constants, codes and the result record of the scanline sprite
// evaluation block.
// ----------------------------------------------------------------------------
`default_nettype none

package sse_pkg;

  // Sprite attribute memory geometry
  localparam int SPRITE_ENTRIES = 64;
  localparam int SLOTS_PER_LINE = 8;
  localparam int ENTRY_BYTES    = 4;
  localparam int MEM_BYTES      = SPRITE_ENTRIES * ENTRY_BYTES;

  localparam int ENTRY_AW = $clog2(SPRITE_ENTRIES);
  localparam int BYTE_AW  = $clog2(MEM_BYTES);
  localparam int SLOT_AW  = (SLOTS_PER_LINE > 1) ? $clog2(SLOTS_PER_LINE) : 1;
  localparam int CNT_W    = $clog2(SLOTS_PER_LINE + 1);

  localparam int WORD_W = 8 * ENTRY_BYTES;
  localparam int SLOT_W = ENTRY_AW + WORD_W;

  // Field widths
  localparam int PTR_W   = 8;
  localparam int BYTE_W  = 8;
  localparam int LINE_W  = 9;
  localparam int IDX_W   = 6;
  localparam int COUNT_W = 4;
  localparam int H_W     = 5;

  localparam logic [LINE_W-1:0] VISIBLE_LINES = 9'd240;
  localparam logic [H_W-1:0]    SHORT_HEIGHT  = 5'd8;
  localparam logic [H_W-1:0]    TALL_HEIGHT   = 5'd16;

  typedef enum logic [1:0] {
    FUNC_SET_PTR = 2'd0,
    FUNC_WRITE   = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_EVAL    = 2'd3
  } func_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  read_data;
    logic [WORD_W-1:0]  slot_entry;
    logic [IDX_W-1:0]   slot_sprite_index;
    logic               slot_valid;
    logic [COUNT_W-1:0] sprite_count;
    logic               sprite_zero_found;
    logic               overflow;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/sse_ram.sv
// ----------------------------------------------------------------------------
// sse_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic                 re,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sse_seq.sv
// ----------------------------------------------------------------------------
// sse_seq
// Sequencer: clears the attribute memory after reset, runs pointer, byte
// access and scanline evaluation transactions, and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sse_seq (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             tall,
  // input transaction
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       func,
  input  wire logic [sse_pkg::PTR_W-1:0]        address,
  input  wire logic [sse_pkg::BYTE_W-1:0]       data,
  input  wire logic [sse_pkg::LINE_W-1:0]       scanline,
  // result transaction
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output sse_pkg::result_t                      res,
  // attribute memory
  output logic                                  mem_we,
  output logic [sse_pkg::ENTRY_AW-1:0]          mem_waddr,
  output logic [sse_pkg::WORD_W-1:0]            mem_wdata,
  output logic                                  mem_re,
  output logic [sse_pkg::ENTRY_AW-1:0]          mem_raddr,
  input  wire logic [sse_pkg::WORD_W-1:0]       mem_rdata,
  // slot buffer
  output logic                                  slot_we,
  output logic [sse_pkg::SLOT_AW-1:0]           slot_waddr,
  output logic [sse_pkg::SLOT_W-1:0]            slot_wdata,
  output logic                                  slot_re,
  output logic [sse_pkg::SLOT_AW-1:0]           slot_raddr,
  input  wire logic [sse_pkg::SLOT_W-1:0]       slot_rdata
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MERGE,
    S_READ_WAIT,
    S_ONE_OUT,
    S_SCAN,
    S_SLOT_RD,
    S_SLOT_LOAD,
    S_SLOT_OUT
  } state_t;

  localparam logic [sse_pkg::ENTRY_AW-1:0] LAST_ENTRY =
    sse_pkg::ENTRY_AW'(sse_pkg::SPRITE_ENTRIES - 1);
  localparam logic [sse_pkg::CNT_W-1:0] FULL_COUNT =
    sse_pkg::CNT_W'(sse_pkg::SLOTS_PER_LINE);

  state_t                            state;
  logic [sse_pkg::PTR_W-1:0]         pointer;
  logic [sse_pkg::ENTRY_AW-1:0]      clr_addr;
  logic [sse_pkg::ENTRY_AW-1:0]      scan_idx;
  logic [sse_pkg::LINE_W-1:0]        line;
  logic [sse_pkg::CNT_W-1:0]         count;
  logic                              zero_found;
  logic                              ovf;
  logic [sse_pkg::CNT_W-1:0]         emit_k;
  logic [sse_pkg::BYTE_W-1:0]        wr_byte;

  logic                              accept;
  logic                              out_take;
  logic [sse_pkg::BYTE_AW-1:0]       ptr_byte;
  logic [1:0]                        lane;
  logic [sse_pkg::WORD_W-1:0]        merged;
  logic [sse_pkg::BYTE_W-1:0]        read_byte;
  logic [sse_pkg::LINE_W-1:0]        y_ext;
  logic [sse_pkg::LINE_W-1:0]        diff;
  logic [sse_pkg::H_W-1:0]           height;
  logic                              hit;
  logic                              full;
  logic [sse_pkg::CNT_W-1:0]         k1;
  logic [sse_pkg::CNT_W-1:0]         k2;

  // Result record for a transaction that is not an evaluation.
  function automatic sse_pkg::result_t plain_result(input logic [sse_pkg::BYTE_W-1:0] rd);
    sse_pkg::result_t r;
    r                   = '0;
    r.read_data         = rd;
    r.slot_entry        = '1;
    r.last              = 1'b1;
    return r;
  endfunction

  // Result record for slot k of an evaluation.
  function automatic sse_pkg::result_t slot_result(
    input logic [sse_pkg::CNT_W-1:0]  k,
    input logic [sse_pkg::SLOT_W-1:0] sd,
    input logic [sse_pkg::CNT_W-1:0]  cnt,
    input logic                       zf,
    input logic                       of
  );
    sse_pkg::result_t r;
    logic             v;
    v                   = (k < cnt);
    r                   = '0;
    r.slot_valid        = v;
    r.slot_entry        = v ? sd[sse_pkg::WORD_W-1:0] : '1;
    r.slot_sprite_index = v ? sse_pkg::IDX_W'(sd[sse_pkg::SLOT_W-1:sse_pkg::WORD_W]) : '0;
    r.sprite_count      = sse_pkg::COUNT_W'(cnt);
    r.sprite_zero_found = zf;
    r.overflow          = of;
    r.last              = (k == sse_pkg::CNT_W'(sse_pkg::SLOTS_PER_LINE - 1));
    return r;
  endfunction

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  assign ptr_byte  = sse_pkg::BYTE_AW'(pointer);
  assign lane      = ptr_byte[1:0];
  assign read_byte = mem_rdata[{lane, 3'b000} +: sse_pkg::BYTE_W];

  always_comb begin
    merged = mem_rdata;
    merged[{lane, 3'b000} +: sse_pkg::BYTE_W] = wr_byte;
  end

  // In-range test of the entry whose word arrives this cycle.
  assign y_ext  = sse_pkg::LINE_W'(mem_rdata[sse_pkg::BYTE_W-1:0]);
  assign diff   = line - y_ext;
  assign height = tall ? sse_pkg::TALL_HEIGHT : sse_pkg::SHORT_HEIGHT;
  assign hit    = (line >= y_ext) && (diff < sse_pkg::LINE_W'(height));
  assign full   = (count == FULL_COUNT);

  assign k1 = emit_k + sse_pkg::CNT_W'(1);
  assign k2 = emit_k + sse_pkg::CNT_W'(2);

  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = ptr_byte[sse_pkg::BYTE_AW-1:2];
    mem_wdata  = merged;
    mem_re     = 1'b0;
    mem_raddr  = ptr_byte[sse_pkg::BYTE_AW-1:2];
    slot_we    = 1'b0;
    slot_waddr = count[sse_pkg::SLOT_AW-1:0];
    slot_wdata = {scan_idx, mem_rdata};
    slot_re    = 1'b0;
    slot_raddr = emit_k[sse_pkg::SLOT_AW-1:0];
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (sse_pkg::func_t'(func))
            sse_pkg::FUNC_WRITE,
            sse_pkg::FUNC_READ: mem_re = 1'b1;
            sse_pkg::FUNC_EVAL: begin
              mem_re    = 1'b1;
              mem_raddr = '0;
            end
            sse_pkg::FUNC_SET_PTR: mem_re = 1'b0;
          endcase
        end
      end
      S_MERGE: mem_we = 1'b1;
      S_SCAN: begin
        // prefetch the next entry while testing this one
        mem_re    = 1'b1;
        mem_raddr = scan_idx + sse_pkg::ENTRY_AW'(1);
        slot_we   = hit && !full;
      end
      S_SLOT_RD: slot_re = 1'b1;
      S_SLOT_LOAD: begin
        slot_re    = 1'b1;
        slot_raddr = k1[sse_pkg::SLOT_AW-1:0];
      end
      S_SLOT_OUT: begin
        slot_re    = out_take && !res.last;
        slot_raddr = k2[sse_pkg::SLOT_AW-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      pointer   <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + sse_pkg::ENTRY_AW'(1);
          if (clr_addr == LAST_ENTRY) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            unique case (sse_pkg::func_t'(func))
              sse_pkg::FUNC_SET_PTR: begin
                pointer   <= address;
                res       <= plain_result('0);
                out_valid <= 1'b1;
                state     <= S_ONE_OUT;
              end
              sse_pkg::FUNC_WRITE: begin
                wr_byte <= data;
                state   <= S_MERGE;
              end
              sse_pkg::FUNC_READ: state <= S_READ_WAIT;
              sse_pkg::FUNC_EVAL: begin
                line       <= scanline;
                count      <= '0;
                zero_found <= 1'b0;
                ovf        <= 1'b0;
                scan_idx   <= '0;
                emit_k     <= '0;
                if (scanline < sse_pkg::VISIBLE_LINES) begin
                  state <= S_SCAN;
                end else begin
                  state <= S_SLOT_RD;
                end
              end
            endcase
          end
        end
        S_MERGE: begin
          pointer   <= pointer + sse_pkg::PTR_W'(1);
          res       <= plain_result('0);
          out_valid <= 1'b1;
          state     <= S_ONE_OUT;
        end
        S_READ_WAIT: begin
          res       <= plain_result(read_byte);
          out_valid <= 1'b1;
          state     <= S_ONE_OUT;
        end
        S_ONE_OUT: begin
          if (out_take) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (hit) begin
            if (!full) begin
              count <= count + sse_pkg::CNT_W'(1);
              if (scan_idx == '0) begin
                zero_found <= 1'b1;
              end
            end else begin
              ovf <= 1'b1;
            end
          end
          // stop at the first extra in-range entry or after the last entry
          if ((hit && full) || scan_idx == LAST_ENTRY) begin
            emit_k <= '0;
            state  <= S_SLOT_RD;
          end else begin
            scan_idx <= scan_idx + sse_pkg::ENTRY_AW'(1);
          end
        end
        S_SLOT_RD: state <= S_SLOT_LOAD;
        S_SLOT_LOAD: begin
          res       <= slot_result(emit_k, slot_rdata, count, zero_found, ovf);
          out_valid <= 1'b1;
          state     <= S_SLOT_OUT;
        end
        S_SLOT_OUT: begin
          if (out_take) begin
            if (res.last) begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end else begin
              emit_k <= k1;
              res    <= slot_result(k1, slot_rdata, count, zero_found, ovf);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // No result leaves while the memory is still being cleared.
  assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !out_valid)
    else $error("result presented during memory clear");

  // Overflow is only flagged once every slot is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && res.overflow |->
      res.sprite_count == sse_pkg::COUNT_W'(sse_pkg::SLOTS_PER_LINE))
    else $error("overflow with free slots");

  // The slot buffer is never written past its last slot.
  assert property (@(posedge clk) disable iff (rst)
    slot_we |-> count < FULL_COUNT)
    else $error("slot buffer overrun");

  // Taking the final result of a transaction empties the result register.
  assert property (@(posedge clk) disable iff (rst)
    out_take && res.last |=> !out_valid)
    else $error("result repeated after last");

endmodule

`default_nettype wire

>>> rtl/core/scanline_sprite_evaluation.sv
// ----------------------------------------------------------------------------
// scanline_sprite_evaluation
// Sprite attribute memory with byte access and per-scanline sprite selection.
//
// Channels: the input channel (in_valid / in_stall) carries func, address,
// data and scanline; one transaction sets the pointer, writes a byte and
// advances the pointer, reads the byte at the pointer, or evaluates a line.
// The result channel (out_valid / out_stall) returns one transaction for the
// pointer and byte functions and one per slot (8) for an evaluation, with
// last high on the final one. The cfg channel (cfg_valid / cfg_ready) writes
// tall_sprites; cfg_ready is always high.
// Set pointer registers its result on acceptance; a write reads the word,
// merges the byte, writes the word back and registers its result; a read
// reads the word, then registers the byte. An evaluation reads the 64
// attribute words one per cycle from the memory's single read port, stopping
// at an in-range entry found with all slots full, then streams the slots from
// the slot buffer, one per cycle while out_stall is low. Scanlines of 240 and
// above skip the scan. One transaction is in flight at a time; in_stall is
// high until its last result is taken; the next transaction can be accepted
// in the following cycle. Reset: a clearing pass writes zero to all 64 memory
// words with in_stall high; pointer and tall_sprites return to zero.
// A stalled result holds in the output register until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module scanline_sprite_evaluation (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic                             cfg_data,
  // input transaction
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       func,
  input  wire logic [sse_pkg::PTR_W-1:0]        address,
  input  wire logic [sse_pkg::BYTE_W-1:0]       data,
  input  wire logic [sse_pkg::LINE_W-1:0]       scanline,
  // result transaction
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [sse_pkg::BYTE_W-1:0]            read_data,
  output logic [sse_pkg::WORD_W-1:0]            slot_entry,
  output logic [sse_pkg::IDX_W-1:0]             slot_sprite_index,
  output logic                                  slot_valid,
  output logic [sse_pkg::COUNT_W-1:0]           sprite_count,
  output logic                                  sprite_zero_found,
  output logic                                  overflow,
  output logic                                  last
);

  logic                                tall_sprites;
  sse_pkg::result_t                    res;

  logic                                mem_we;
  logic [sse_pkg::ENTRY_AW-1:0]        mem_waddr;
  logic [sse_pkg::WORD_W-1:0]          mem_wdata;
  logic                                mem_re;
  logic [sse_pkg::ENTRY_AW-1:0]        mem_raddr;
  logic [sse_pkg::WORD_W-1:0]          mem_rdata;

  logic                                slot_we;
  logic [sse_pkg::SLOT_AW-1:0]         slot_waddr;
  logic [sse_pkg::SLOT_W-1:0]          slot_wdata;
  logic                                slot_re;
  logic [sse_pkg::SLOT_AW-1:0]         slot_raddr;
  logic [sse_pkg::SLOT_W-1:0]          slot_rdata;

  // Config is always taken; user writes must arrive only while idle, unchecked.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tall_sprites <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      tall_sprites <= cfg_data;
    end
  end

  // Attribute memory: one 32-bit word per sprite, y in the low byte.
  sse_ram #(
    .WIDTH (sse_pkg::WORD_W),
    .DEPTH (sse_pkg::SPRITE_ENTRIES)
  ) u_attr_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Slot buffer: selected word and entry number per slot.
  sse_ram #(
    .WIDTH (sse_pkg::SLOT_W),
    .DEPTH (sse_pkg::SLOTS_PER_LINE)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  sse_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .tall       (tall_sprites),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .address    (address),
    .data       (data),
    .scanline   (scanline),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .slot_we    (slot_we),
    .slot_waddr (slot_waddr),
    .slot_wdata (slot_wdata),
    .slot_re    (slot_re),
    .slot_raddr (slot_raddr),
    .slot_rdata (slot_rdata)
  );

  // Unpack the result register onto the field ports.
  assign read_data         = res.read_data;
  assign slot_entry        = res.slot_entry;
  assign slot_sprite_index = res.slot_sprite_index;
  assign slot_valid        = res.slot_valid;
  assign sprite_count      = res.sprite_count;
  assign sprite_zero_found = res.sprite_zero_found;
  assign overflow          = res.overflow;
  assign last              = res.last;

endmodule

`default_nettype wire

>>> tb/tb_scanline_sprite_evaluation.sv
// ----------------------------------------------------------------------------
// tb_scanline_sprite_evaluation
// Self-checking bench for the scanline sprite evaluation block. A shadow
// copy of the attribute memory, pointer and sprite height predicts every
// result transaction. A monitor compares each accepted result, field by
// field, with the oldest prediction. Directed corner cases come first.
// Random sprite tables and scanline sweeps follow, under several
// idle/stall mixes, a long receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_scanline_sprite_evaluation;
  timeunit 1ns;
  timeprecision 1ps;

  import sse_pkg::*;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          func;
  logic [PTR_W-1:0]    address;
  logic [BYTE_W-1:0]   data;
  logic [LINE_W-1:0]   scanline;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [BYTE_W-1:0]   read_data;
  logic [WORD_W-1:0]   slot_entry;
  logic [IDX_W-1:0]    slot_sprite_index;
  logic                slot_valid;
  logic [COUNT_W-1:0]  sprite_count;
  logic                sprite_zero_found;
  logic                overflow;
  logic                last;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  scanline_sprite_evaluation u_top (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .func              (func),
    .address           (address),
    .data              (data),
    .scanline          (scanline),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .read_data         (read_data),
    .slot_entry        (slot_entry),
    .slot_sprite_index (slot_sprite_index),
    .slot_valid        (slot_valid),
    .sprite_count      (sprite_count),
    .sprite_zero_found (sprite_zero_found),
    .overflow          (overflow),
    .last              (last)
  );

  // --------------------------------------------------------------------------
  // Shadow state: what the block should hold after every accepted transaction
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0] oam_shadow [MEM_BYTES];
  logic [PTR_W-1:0]  ptr_shadow;
  logic              tall_shadow;

  // Result transactions still owed by the block, oldest first
  result_t pending_slots [$];

  int fail_count     = 0;
  int items_sent     = 0;
  int send_idle_pct  = 0;   // chance per cycle that the sender sits idle
  int recv_stall_pct = 0;   // chance per cycle that the receiver stalls
  int holdoff_cycles = 0;   // long receiver hold-off, counted down by monitor
  int hot_line       = 100; // scanline that random sprite tables crowd around

  // --------------------------------------------------------------------------
  // Predictor: apply one accepted transaction to the shadow state and queue
  // the result transactions it must produce.
  // --------------------------------------------------------------------------
  task automatic apply_sprite_op(input func_t f, input logic [PTR_W-1:0] addr,
                                 input logic [BYTE_W-1:0] dat,
                                 input logic [LINE_W-1:0] line);
    result_t           r;
    logic [WORD_W-1:0] words [SLOTS_PER_LINE];
    logic [IDX_W-1:0]  idx   [SLOTS_PER_LINE];
    int                count;
    int                height;
    int                y;
    int                base;
    logic              zero;
    logic              ovf;
    r            = '0;
    r.slot_entry = '1;
    r.last       = 1'b1;
    count        = 0;
    zero         = 1'b0;
    ovf          = 1'b0;
    case (f)
      FUNC_SET_PTR: begin
        ptr_shadow = addr;
        pending_slots.push_back(r);
      end
      FUNC_WRITE: begin
        // Write, then advance the pointer; it wraps at 8 bits
        oam_shadow[int'(ptr_shadow) % MEM_BYTES] = dat;
        ptr_shadow = ptr_shadow + 1'b1;
        pending_slots.push_back(r);
      end
      FUNC_READ: begin
        // A read leaves the pointer where it is
        r.read_data = oam_shadow[int'(ptr_shadow) % MEM_BYTES];
        pending_slots.push_back(r);
      end
      default: begin
        height = tall_shadow ? 16 : 8;
        // Lines past the visible area select nothing at all
        if (line < VISIBLE_LINES) begin
          for (int i = 0; i < SPRITE_ENTRIES; i++) begin
            base = i * ENTRY_BYTES;
            y    = oam_shadow[base];
            if (int'(line) >= y && int'(line) - y < height) begin
              if (count < SLOTS_PER_LINE) begin
                if (i == 0) zero = 1'b1;
                words[count] = {oam_shadow[base+3], oam_shadow[base+2],
                                oam_shadow[base+1], oam_shadow[base]};
                idx[count]   = IDX_W'(i);
                count++;
              end else begin
                // Stop the scan at the first sprite that does not fit
                ovf = 1'b1;
                break;
              end
            end
          end
        end
        // Always one transaction per slot; empty slots read all ones
        for (int k = 0; k < SLOTS_PER_LINE; k++) begin
          r                   = '0;
          r.slot_entry        = '1;
          r.sprite_count      = COUNT_W'(count);
          r.sprite_zero_found = zero;
          r.overflow          = ovf;
          r.last              = (k == SLOTS_PER_LINE - 1);
          if (k < count) begin
            r.slot_entry        = words[k];
            r.slot_sprite_index = idx[k];
            r.slot_valid        = 1'b1;
          end
          pending_slots.push_back(r);
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Sender: offer one transaction, hold it until accepted, then predict.
  // Valid stays high into the next transaction unless an idle gap is drawn.
  // --------------------------------------------------------------------------
  task automatic send_item(input func_t f, input logic [PTR_W-1:0] addr,
                           input logic [BYTE_W-1:0] dat,
                           input logic [LINE_W-1:0] line);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    address  <= addr;
    data     <= dat;
    scanline <= line;
    do @(posedge clk); while (in_stall);
    apply_sprite_op(f, addr, dat, line);
    items_sent++;
  endtask

  // Unused fields carry random noise so that every input bit toggles
  task automatic send_set_ptr(input int a);
    send_item(FUNC_SET_PTR, PTR_W'(a), BYTE_W'($urandom_range(255)),
              LINE_W'($urandom_range(511)));
  endtask

  task automatic send_write(input int d);
    send_item(FUNC_WRITE, PTR_W'($urandom_range(255)), BYTE_W'(d),
              LINE_W'($urandom_range(511)));
  endtask

  task automatic send_read();
    send_item(FUNC_READ, PTR_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
              LINE_W'($urandom_range(511)));
  endtask

  task automatic send_eval(input int line);
    send_item(FUNC_EVAL, PTR_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
              LINE_W'(line));
  endtask

  // Fill one sprite entry: y first, then tile, attributes and x
  task automatic write_sprite(input int entry, input int y);
    send_set_ptr(entry * ENTRY_BYTES);
    send_write(y);
    repeat (ENTRY_BYTES - 1) send_write($urandom_range(255));
  endtask

  // Drop valid and hold until every owed result has been taken
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_slots.size() != 0);
  endtask

  // Change the sprite height only while the block is idle
  task automatic write_tall(input logic v);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    tall_shadow = v;
  endtask

  // --------------------------------------------------------------------------
  // Result monitor: check every accepted result and drive out_stall.
  // The long hold-off is counted down here, one cycle per clock.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    result_t got;
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{read_data, slot_entry, slot_sprite_index, slot_valid,
                sprite_count, sprite_zero_found, overflow, last};
        if (pending_slots.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result transaction: entry=%h idx=%0d last=%b",
                     slot_entry, slot_sprite_index, last);
        end else begin
          want = pending_slots.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch at %0t", $realtime);
              $display("  expected rd=%h entry=%h idx=%0d v=%b cnt=%0d z=%b ovf=%b last=%b",
                       want.read_data, want.slot_entry, want.slot_sprite_index,
                       want.slot_valid, want.sprite_count, want.sprite_zero_found,
                       want.overflow, want.last);
              $display("  actual   rd=%h entry=%h idx=%0d v=%b cnt=%0d z=%b ovf=%b last=%b",
                       got.read_data, got.slot_entry, got.slot_sprite_index,
                       got.slot_valid, got.sprite_count, got.sprite_zero_found,
                       got.overflow, got.last);
            end
          end
        end
      end
      if (holdoff_cycles > 0) begin
        out_stall <= 1'b1;
        holdoff_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corner cases: reset contents, pointer wrap, height boundaries, lines past
  // the visible area, a full line with overflow, and the entry 0 flag.
  task automatic test_directed_cases();
    send_read();                 // reset memory reads zero
    send_eval(0);                // every entry at y 0: eight slots plus overflow
    send_eval(7);                // bottom row of an 8-line sprite
    send_eval(8);                // one line below: nothing
    send_eval(240);              // first line past the visible area
    send_eval(511);
    send_set_ptr(255);
    send_write(8'hFF);           // pointer wraps to 0 after this write
    send_read();                 // reads byte 0, still zero
    send_set_ptr(255);
    send_read();                 // reads back the byte at the top
    send_set_ptr(0);
    send_write(230);             // entry 0 moves low on the screen
    send_write(8'h00);
    send_write(8'hFF);
    send_write(8'h5A);
    send_eval(237);              // entry 0 alone, zero flag set
    write_tall(1'b1);
    send_eval(239);              // nine lines below y: only tall sprites reach
    send_eval(15);               // bottom row of a 16-line sprite, overflow
    send_eval(16);               // one line below: nothing
    write_tall(1'b0);
  endtask

  // Random traffic: mostly sprite entries crowded around one scanline and
  // evaluations near it, with reads, bursts and plain noise mixed in.
  task automatic run_random_traffic(input int n);
    int stop_at;
    int pick;
    int y;
    stop_at  = items_sent + n;
    hot_line = $urandom_range(8, 239);
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        case ($urandom_range(3))
          0, 1:    y = hot_line - $urandom_range(0, 17);
          2:       y = $urandom_range(255);
          default: y = $urandom_range(8'hEF, 8'hFF);
        endcase
        if (y < 0) y = 0;
        write_sprite($urandom_range(SPRITE_ENTRIES - 1), y);
      end else if (pick < 65) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: send_eval(hot_line + $urandom_range(0, 17) - 2);
          5, 6, 7:       send_eval($urandom_range(239));
          default:       send_eval($urandom_range(240, 511));
        endcase
      end else if (pick < 75) begin
        send_set_ptr($urandom_range(255));
        repeat ($urandom_range(1, 3)) send_read();
      end else if (pick < 85) begin
        // Burst writes may run across the top of memory and wrap
        send_set_ptr($urandom_range(255));
        repeat ($urandom_range(1, 8)) send_write($urandom_range(255));
      end else begin
        send_item(func_t'($urandom_range(3)), PTR_W'($urandom_range(255)),
                  BYTE_W'($urandom_range(255)), LINE_W'($urandom_range(511)));
      end
    end
  endtask

  task automatic test_short_sprites_streaming();
    write_tall(1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_traffic(85);
  endtask

  task automatic test_tall_sprites_sender_gaps();
    write_tall(1'b1);
    send_idle_pct  = 75;
    recv_stall_pct = 0;
    run_random_traffic(85);
  endtask

  task automatic test_short_sprites_receiver_stalls();
    write_tall(1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 75;
    run_random_traffic(85);
  endtask

  task automatic test_tall_sprites_both_idle();
    write_tall(1'b1);
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    run_random_traffic(85);
  endtask

  // Hold the receiver off for a long stretch while the sender keeps
  // offering; the block fills up and must stall its input.
  task automatic test_receiver_holdoff();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_cycles = 400;
    repeat (15) begin
      if ($urandom_range(1)) send_eval(hot_line + $urandom_range(0, 7));
      else send_write($urandom_range(255));
    end
  endtask

  // Pause the sender until every result is back, several times over
  task automatic test_sender_drain_pause();
    write_tall(1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 40;
    repeat (5) begin
      run_random_traffic(4);
      wait_drain();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst         <= 1'b1;
    cfg_valid   <= 1'b0;
    cfg_data    <= 1'b0;
    in_valid    <= 1'b0;
    func        <= FUNC_SET_PTR;
    address     <= '0;
    data        <= '0;
    scanline    <= '0;
    ptr_shadow  = '0;
    tall_shadow = 1'b0;
    foreach (oam_shadow[i]) oam_shadow[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_short_sprites_streaming();
    test_tall_sprites_sender_gaps();
    test_short_sprites_receiver_stalls();
    test_tall_sprites_both_idle();
    test_receiver_holdoff();
    test_sender_drain_pause();

    // Let stray results show up before the verdict
    wait_drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_slots.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/sse_pkg.sv
rtl/core/sse_ram.sv
rtl/core/sse_seq.sv
rtl/core/scanline_sprite_evaluation.sv
tb/tb_scanline_sprite_evaluation.sv
